[hw/rtl/tas_pkg.sv]
`default_nettype none

package tas_pkg;

   // lengths are kept in units of 1/51200 tile so every constant is an integer
   localparam int LenW = 16;
   localparam logic signed [17:0] DispMax = 18'sd51200;
   localparam logic signed [17:0] LenMargin = 18'sd512;
   localparam logic [LenW-1:0] LenSide = 16'd52224;

   // weight = floor((x * y + RoundBias) / (16 * DivConst)), rounds to nearest
   localparam int ProdW = 32;
   localparam int SclW = 28;
   localparam int QuotW = 17;
   localparam int RemW = 13;
   localparam int WtW = 17;
   localparam int FracW = 16;
   localparam logic [ProdW-1:0] RoundBias = 32'd20808;
   localparam int DivShift = 4;
   localparam logic [11:0] DivConst = 12'd2601;

   // reciprocal of the divisor, good to within one for scaled values below 2^28
   localparam int RecipShift = 32;
   localparam int RecipMulW = 21;
   localparam int RecipW = SclW + RecipMulW;
   localparam longint unsigned RecipFull = (64'd1 << RecipShift) / 64'd2601;
   localparam logic [RecipMulW-1:0] RecipMul = RecipMulW'(RecipFull);

   localparam int AmtW = 32;
   localparam int NumLane = 8;

   // lane codes for the eight neighbours
   localparam int LaneLu = 0;
   localparam int LaneU = 1;
   localparam int LaneRu = 2;
   localparam int LaneL = 3;
   localparam int LaneR = 4;
   localparam int LaneLd = 5;
   localparam int LaneD = 6;
   localparam int LaneRd = 7;

   // column (left, middle, right) and row (up, middle, down) of each lane
   localparam logic [1:0] LaneCol [NumLane] = '{2'd0, 2'd1, 2'd2, 2'd0,
                                                2'd2, 2'd0, 2'd1, 2'd2};
   localparam logic [1:0] LaneRow [NumLane] = '{2'd0, 2'd0, 2'd0, 2'd1,
                                                2'd1, 2'd2, 2'd2, 2'd2};

   localparam int QueueDepthDef = 4;

   typedef struct packed {
      logic signed [15:0] velocity_x;
      logic signed [15:0] velocity_y;
      logic               has_left;
      logic               has_up;
      logic               has_right;
      logic               has_down;
      logic [31:0]        nutrient;
   } req_type;

   typedef struct packed {
      logic [31:0] amount_left_up;
      logic [31:0] amount_up;
      logic [31:0] amount_right_up;
      logic [31:0] amount_left;
      logic [31:0] amount_keep;
      logic [31:0] amount_right;
      logic [31:0] amount_left_down;
      logic [31:0] amount_down;
      logic [31:0] amount_right_down;
   } rsp_type;

   // low overhang, inside, high overhang of one axis
   typedef logic [2:0][LenW-1:0] len3_type;

   typedef struct packed {
      logic        has_left;
      logic        has_up;
      logic        has_right;
      logic        has_down;
      logic [31:0] nutrient;
   } side_type;

   typedef struct packed {
      len3_type x_len;
      len3_type y_len;
      side_type side;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } enq_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } deq_type;

endpackage

`default_nettype wire

[hw/rtl/tas_front.sv]
`default_nettype none

module tas_front import tas_pkg::*; (
   input  logic    start,
   input  logic    busy,
   input  req_type req,
   output enq_type enq
);

   // displacement, saturation and overhang lengths of one axis
   function automatic len3_type split_axis(input logic signed [15:0] vel);
      logic signed [17:0] disp;
      logic signed [17:0] lo_s;
      logic signed [17:0] hi_s;
      logic [LenW-1:0]    lo;
      logic [LenW-1:0]    hi;
      len3_type           res;
      disp = {{2{vel[15]}}, vel} + {vel[15], vel, 1'b0};
      if (disp > DispMax) begin
         disp = DispMax;
      end else if (disp < -DispMax) begin
         disp = -DispMax;
      end
      lo_s = LenMargin - disp;
      hi_s = LenMargin + disp;
      lo = lo_s[17] ? '0 : lo_s[LenW-1:0];
      hi = hi_s[17] ? '0 : hi_s[LenW-1:0];
      res[0] = lo;
      res[1] = LenSide - lo - hi;
      res[2] = hi;
      return res;
   endfunction

   // classify the transaction and hand it to the queue
   always_comb begin
      enq.push = start & ~busy;
      enq.job.x_len = split_axis(req.velocity_x);
      enq.job.y_len = split_axis(req.velocity_y);
      enq.job.side.has_left = req.has_left;
      enq.job.side.has_up = req.has_up;
      enq.job.side.has_right = req.has_right;
      enq.job.side.has_down = req.has_down;
      enq.job.side.nutrient = req.nutrient;
   end

endmodule

`default_nettype wire

[hw/rtl/tas_queue.sv]
`default_nettype none

module tas_queue import tas_pkg::*; #(
   parameter int Depth = QueueDepthDef
) (
   input  logic    clock,
   input  logic    reset,
   input  enq_type enq,
   input  logic    pop,
   output deq_type head,
   output logic    full
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   job_type         slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            do_pop;

   // pointer and fill count update
   always_comb begin
      do_pop = pop & (cnt_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (enq.push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + CntW'(enq.push) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (enq.push) begin
         slot_ff[wr_ptr_ff] <= enq.job;
      end
   end

   assign head.valid = (cnt_ff != '0);
   assign head.job = slot_ff[rd_ptr_ff];
   assign full = (cnt_ff == CntW'(Depth));

endmodule

`default_nettype wire

[hw/rtl/tas_back.sv]
`default_nettype none

module tas_back import tas_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  deq_type head,
   output logic    pop,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int NumStage = 10;
   localparam int NumSide = NumStage - 1;

   logic [NumStage-1:0] vld_ff, vld_in;
   side_type            side_ff [NumSide];

   logic [ProdW-1:0]  prod_ff [NumLane];
   logic [ProdW-1:0]  prod_in [NumLane];
   logic [SclW-1:0]   scl_ff [NumLane];
   logic [SclW-1:0]   scl_in [NumLane];
   logic [SclW-1:0]   scl2_ff [NumLane];
   logic [RecipW-1:0] recip_ff [NumLane];
   logic [RecipW-1:0] recip_in [NumLane];
   logic [QuotW-1:0]  quot_ff [NumLane];
   logic [QuotW-1:0]  quot_in [NumLane];
   logic [RemW-1:0]   rem_ff [NumLane];
   logic [RemW-1:0]   rem_in [NumLane];
   logic [WtW-1:0]    wt_ff [NumLane];
   logic [WtW-1:0]    wt_in [NumLane];
   logic [WtW-1:0]    fold_ff [NumLane];
   logic [WtW-1:0]    fold_in [NumLane];
   logic [AmtW-1:0]   amt_ff [NumLane];
   logic [AmtW-1:0]   amt_in [NumLane];
   logic [AmtW-1:0]   amt8_ff [NumLane];
   logic [AmtW-1:0]   amt9_ff [NumLane];
   logic [AmtW-1:0]   pair_ff [4];
   logic [AmtW-1:0]   pair_in [4];
   logic [AmtW-1:0]   half_ff [2];
   logic [AmtW-1:0]   half_in [2];
   rsp_type           rsp_ff, rsp_in;
   side_type          fs;

   // the back end never stalls: take the queue head whenever there is one
   assign pop = head.valid;
   assign vld_in = {vld_ff[NumStage-2:0], head.valid};

   // per-lane area products, reciprocal divide and share
   always_comb begin
      for (int k = 0; k < NumLane; k++) begin
         prod_in[k] = ProdW'(head.job.x_len[LaneCol[k]]) * ProdW'(head.job.y_len[LaneRow[k]]);
         scl_in[k] = SclW'((prod_ff[k] + RoundBias) >> DivShift);
         recip_in[k] = RecipW'(scl_ff[k]) * RecipW'(RecipMul);
         quot_in[k] = recip_ff[k][RecipShift +: QuotW];
         rem_in[k] = RemW'(scl2_ff[k] - SclW'(quot_in[k]) * SclW'(DivConst));
         wt_in[k] = quot_ff[k] + WtW'(rem_ff[k] >= RemW'(DivConst));
         amt_in[k] = AmtW'(((AmtW + WtW)'(side_ff[5].nutrient) *
                            (AmtW + WtW)'(fold_ff[k])) >> FracW);
      end
   end

   // fold shares of missing neighbours back toward the centre, columns first
   always_comb begin
      fs = side_ff[4];
      fold_in[LaneLu] = (fs.has_left & fs.has_up) ? wt_ff[LaneLu] : '0;
      fold_in[LaneRu] = (fs.has_right & fs.has_up) ? wt_ff[LaneRu] : '0;
      fold_in[LaneLd] = (fs.has_left & fs.has_down) ? wt_ff[LaneLd] : '0;
      fold_in[LaneRd] = (fs.has_right & fs.has_down) ? wt_ff[LaneRd] : '0;
      fold_in[LaneU] = fs.has_up ? wt_ff[LaneU]
                       + (fs.has_left ? '0 : wt_ff[LaneLu])
                       + (fs.has_right ? '0 : wt_ff[LaneRu]) : '0;
      fold_in[LaneD] = fs.has_down ? wt_ff[LaneD]
                       + (fs.has_left ? '0 : wt_ff[LaneLd])
                       + (fs.has_right ? '0 : wt_ff[LaneRd]) : '0;
      fold_in[LaneL] = fs.has_left ? wt_ff[LaneL]
                       + (fs.has_up ? '0 : wt_ff[LaneLu])
                       + (fs.has_down ? '0 : wt_ff[LaneLd]) : '0;
      fold_in[LaneR] = fs.has_right ? wt_ff[LaneR]
                       + (fs.has_up ? '0 : wt_ff[LaneRu])
                       + (fs.has_down ? '0 : wt_ff[LaneRd]) : '0;
   end

   // share sum tree and the remainder kept by the centre
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         pair_in[k] = amt_ff[2 * k] + amt_ff[2 * k + 1];
      end
      for (int k = 0; k < 2; k++) begin
         half_in[k] = pair_ff[2 * k] + pair_ff[2 * k + 1];
      end
      rsp_in.amount_left_up = amt9_ff[LaneLu];
      rsp_in.amount_up = amt9_ff[LaneU];
      rsp_in.amount_right_up = amt9_ff[LaneRu];
      rsp_in.amount_left = amt9_ff[LaneL];
      rsp_in.amount_keep = side_ff[8].nutrient - half_ff[0] - half_ff[1];
      rsp_in.amount_right = amt9_ff[LaneR];
      rsp_in.amount_left_down = amt9_ff[LaneLd];
      rsp_in.amount_down = amt9_ff[LaneD];
      rsp_in.amount_right_down = amt9_ff[LaneRd];
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      side_ff[0] <= head.job.side;
      for (int s = 1; s < NumSide; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
      for (int k = 0; k < NumLane; k++) begin
         prod_ff[k] <= prod_in[k];
         scl_ff[k] <= scl_in[k];
         scl2_ff[k] <= scl_ff[k];
         recip_ff[k] <= recip_in[k];
         quot_ff[k] <= quot_in[k];
         rem_ff[k] <= rem_in[k];
         wt_ff[k] <= wt_in[k];
         fold_ff[k] <= fold_in[k];
         amt_ff[k] <= amt_in[k];
         amt8_ff[k] <= amt_ff[k];
         amt9_ff[k] <= amt8_ff[k];
      end
      for (int k = 0; k < 4; k++) begin
         pair_ff[k] <= pair_in[k];
      end
      for (int k = 0; k < 2; k++) begin
         half_ff[k] <= half_in[k];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = vld_ff[NumStage-1];
   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

[hw/rtl/tile_advection_split_unit.sv]
`default_nettype none

// Splits one tile's nutrient over the tile and its eight neighbours by the
// area overlap of a widened, displaced unit square. A transaction is taken
// on every clock edge where start is high and busy is low, so one tile per
// cycle is sustained. Its result shows on rsp_data with rsp_strobe high for
// one cycle, after the queue and the back-end pipeline; the receiver cannot
// hold results off, and nothing in the back end waits. The pace is set by
// the eight weight lanes, each with one multiplier per pipeline stage
// (area product, reciprocal divide, share). busy is high only when the
// transaction queue between the classifier and the back end is full.

module tile_advection_split_unit import tas_pkg::*; #(
   parameter int QueueDepth = QueueDepthDef
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   enq_type enq;
   deq_type head;
   logic    pop;

   // front: classify the transaction
   tas_front u_front (
      .start (start),
      .busy  (busy),
      .req   (req_data),
      .enq   (enq)
   );

   // queue between front and back
   tas_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .enq   (enq),
      .pop   (pop),
      .head  (head),
      .full  (busy)
   );

   // back: weights, folding and shares
   tas_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

[tb/tas_split_checker.sv]
`timescale 1ns / 1ps

module tas_split_checker import tas_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      open_count
);

   // geometry in units of 1/256000 tile
   localparam longint UnitLen = 256000;
   localparam longint MarginLen = 2560;
   localparam longint DispScale = 15;
   localparam longint SideLen = UnitLen + 2 * MarginLen;
   localparam longint SideArea = SideLen * SideLen;
   localparam int ReportMax = 10;

   rsp_type amounts_due [$];
   rsp_type want;
   logic [8:0][31:0] want_v;
   logic [8:0][31:0] got_v;

   function automatic string field_label(input int k);
      case (k)
         0: return "amount_left_up";
         1: return "amount_up";
         2: return "amount_right_up";
         3: return "amount_left";
         4: return "amount_keep";
         5: return "amount_right";
         6: return "amount_left_down";
         7: return "amount_down";
         default: return "amount_right_down";
      endcase
   endfunction

   // low overhang, inside and high overhang of one axis
   function automatic void axis_split(input logic signed [15:0] vel, output longint lo,
                                      output longint mid, output longint hi);
      longint d;
      d = longint'(vel) * DispScale;
      if (d > UnitLen) d = UnitLen;
      if (d < -UnitLen) d = -UnitLen;
      lo = MarginLen - d;
      hi = MarginLen + d;
      if (lo < 0) lo = 0;
      if (hi < 0) hi = 0;
      mid = SideLen - lo - hi;
   endfunction

   // nine amounts of one tile, centre takes the remainder
   function automatic rsp_type split_nutrient(input req_type t);
      longint xs [3];
      longint ys [3];
      longint wt [3][3];
      longint unsigned nut;
      longint unsigned share;
      longint unsigned spent;
      logic [8:0][31:0] amt;
      int i;
      int j;
      int idx;
      axis_split(t.velocity_x, xs[0], xs[1], xs[2]);
      axis_split(t.velocity_y, ys[0], ys[1], ys[2]);
      // wt[x][y]: x 0 is left, y 0 is up
      for (i = 0; i < 3; i++)
         for (j = 0; j < 3; j++)
            if (i == 1 && j == 1) wt[i][j] = 0;
            else wt[i][j] = (xs[i] * ys[j] * 65536 + SideArea / 2) / SideArea;
      // missing columns fold into the middle column
      for (j = 0; j < 3; j++) begin
         if (!t.has_left) begin
            wt[1][j] += wt[0][j];
            wt[0][j] = 0;
         end
         if (!t.has_right) begin
            wt[1][j] += wt[2][j];
            wt[2][j] = 0;
         end
      end
      // then missing rows fold into the middle row
      for (i = 0; i < 3; i++) begin
         if (!t.has_up) begin
            wt[i][1] += wt[i][0];
            wt[i][0] = 0;
         end
         if (!t.has_down) begin
            wt[i][1] += wt[i][2];
            wt[i][2] = 0;
         end
      end
      nut = longint'(t.nutrient);
      spent = 0;
      amt = '0;
      for (j = 0; j < 3; j++)
         for (i = 0; i < 3; i++) begin
            idx = j * 3 + i;
            if (!(i == 1 && j == 1)) begin
               share = (nut * wt[i][j]) >> 16;
               spent += share;
               amt[8-idx] = share[31:0];
            end
         end
      amt[4] = 32'(nut - spent);
      return rsp_type'(amt);
   endfunction

   // predict on accepted transactions, compare on strobed results
   always @(posedge clock) begin
      if (reset) begin
         amounts_due.delete();
         fail_count = 0;
      end else begin
         if (start && !busy) amounts_due.push_back(split_nutrient(req_data));
         if (rsp_strobe) begin
            if (amounts_due.size() == 0) begin
               fail_count++;
               if (fail_count <= ReportMax)
                  $display("%0t: result with no transaction pending: %h", $time, rsp_data);
            end else begin
               want = amounts_due.pop_front();
               want_v = want;
               got_v = rsp_data;
               for (int k = 0; k < 9; k++)
                  if (got_v[8-k] !== want_v[8-k]) begin
                     fail_count++;
                     if (fail_count <= ReportMax)
                        $display("%0t: %s expected %h got %h", $time, field_label(k),
                                 want_v[8-k], got_v[8-k]);
                  end
            end
         end
      end
      open_count = amounts_due.size();
   end

endmodule

[tb/tb_tile_advection_split_unit.sv]
`timescale 1ns / 1ps

module tb_tile_advection_split_unit import tas_pkg::*;;

   localparam int StallLimit = 5000;
   localparam int SettleCycles = 20;
   localparam int PhaseItems = 288;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      open_count;
   int      stall_cycles;

   tile_advection_split_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   tas_split_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog on cycles where no transaction and no result moves
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= StallLimit) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // flags are left, up, right, down from msb to lsb
   function automatic req_type make_tile(input int vx, input int vy, input logic [3:0] nb,
                                         input logic [31:0] nut);
      req_type t;
      t.velocity_x = vx[15:0];
      t.velocity_y = vy[15:0];
      t.has_left = nb[3];
      t.has_up = nb[2];
      t.has_right = nb[1];
      t.has_down = nb[0];
      t.nutrient = nut;
      return t;
   endfunction

   // mix of full range, margin crossings, saturation edge and extremes
   function automatic int rand_velocity();
      int v;
      case ($urandom_range(9))
         4, 5, 6: begin
            v = $urandom_range(800);
            v = v - 400;
         end
         7: begin
            v = $urandom_range(17130, 17000);
            if ($urandom_range(1)) v = -v;
         end
         8: begin
            case ($urandom_range(5))
               0: v = -32768;
               1: v = 32767;
               2: v = 0;
               3: v = 170;
               4: v = -171;
               default: v = 17067;
            endcase
         end
         default: v = $urandom();
      endcase
      return v;
   endfunction

   function automatic logic [31:0] rand_nutrient();
      case ($urandom_range(9))
         0: return 32'h0;
         1: return 32'hffff_ffff;
         2: return $urandom_range(255);
         default: return $urandom();
      endcase
   endfunction

   // drive at the falling edge and hold until the block takes it
   task automatic send_tile(input req_type t);
      req_data <= t;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic idle_gap(input int pct);
      int n;
      n = 0;
      while (n < 40 && $urandom_range(99) < pct) n++;
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic drain_all();
      start <= 1'b0;
      @(negedge clock);
      while (open_count != 0) @(negedge clock);
   endtask

   req_type directed [$];
   int idle_pct [4] = '{0, 48, 9, 0};

   initial begin
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // field extremes, margin and saturation edges, each single missing side and some other fold patterns
      directed.push_back(make_tile(0, 0, 4'b1111, 32'hffff_ffff));
      directed.push_back(make_tile(0, 0, 4'b1111, 32'h0));
      directed.push_back(make_tile(0, 0, 4'b0000, 32'hffff_ffff));
      directed.push_back(make_tile(32767, 32767, 4'b1111, 32'hffff_ffff));
      directed.push_back(make_tile(-32768, -32768, 4'b1111, 32'hffff_ffff));
      directed.push_back(make_tile(32767, -32768, 4'b1111, 32'h1234_5678));
      directed.push_back(make_tile(-32768, 32767, 4'b0000, 32'hffff_ffff));
      directed.push_back(make_tile(17066, 0, 4'b1111, 32'hffff_ffff));
      directed.push_back(make_tile(17067, -17067, 4'b1111, 32'hffff_ffff));
      directed.push_back(make_tile(-17066, 17066, 4'b1111, 32'hffff_ffff));
      directed.push_back(make_tile(170, 171, 4'b1111, 32'hffff_ffff));
      directed.push_back(make_tile(-171, -170, 4'b1111, 32'hffff_ffff));
      directed.push_back(make_tile(171, 0, 4'b0111, 32'hffff_ffff));
      directed.push_back(make_tile(-171, 0, 4'b1101, 32'hffff_ffff));
      directed.push_back(make_tile(0, 171, 4'b1110, 32'hffff_ffff));
      directed.push_back(make_tile(0, -171, 4'b1011, 32'hffff_ffff));
      directed.push_back(make_tile(20000, 20000, 4'b0101, 32'hffff_ffff));
      directed.push_back(make_tile(20000, -20000, 4'b1010, 32'hffff_ffff));
      directed.push_back(make_tile(-20000, 20000, 4'b0000, 32'hffff_0000));
      directed.push_back(make_tile(100, -100, 4'b1111, 32'h1));
      directed.push_back(make_tile(1, 1, 4'b1111, 32'h0001_0000));
      directed.push_back(make_tile(-1, -1, 4'b1111, 32'hffff_ffff));
      directed.push_back(make_tile(256, 256, 4'b1111, 32'h8000_0000));
      directed.push_back(make_tile(5000, -5000, 4'b1100, 32'hdead_beef));
      foreach (directed[k]) send_tile(directed[k]);

      // hold off until every result of the directed part is back
      drain_all();

      // random transactions under each idling pattern
      for (int p = 0; p < 4; p++) begin
         for (int n = 0; n < PhaseItems; n++) begin
            idle_gap(idle_pct[p]);
            send_tile(make_tile(rand_velocity(), rand_velocity(), 4'($urandom()),
                                rand_nutrient()));
         end
         if (p == 1) drain_all();
      end

      drain_all();
      repeat (SettleCycles) @(negedge clock);
      if (fail_count == 0 && open_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/tas_pkg.sv
hw/rtl/tas_front.sv
hw/rtl/tas_queue.sv
hw/rtl/tas_back.sv
hw/rtl/tile_advection_split_unit.sv
tb/tas_split_checker.sv
tb/tb_tile_advection_split_unit.sv
